// ----- hw/rtl/dense_layer_forward_macros.svh -----
// assertion helpers for the checker file dlf_chk.sv
`ifndef DENSE_LAYER_FORWARD_MACROS_SVH
`define DENSE_LAYER_FORWARD_MACROS_SVH

// antecedent in one cycle, consequent in the next
`define DLF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

// antecedent in one cycle, consequent checked after a delay
`define DLF_ASSERT_AFTER2(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error("%m: check failed");

`endif

// ----- hw/rtl/dlf_pkg.sv -----
`default_nettype none

package dlf_pkg;

  localparam int MAX_INPUTS  = 64;
  localparam int MAX_OUTPUTS = 64;
  localparam int VALUE_BITS  = 16;
  localparam int FRAC_BITS   = VALUE_BITS / 2;
  localparam int ACC_BITS    = 48;
  localparam int COUNT_BITS  = 7;
  localparam int ROW_BITS    = 6;
  localparam int COL_BITS    = 6;
  localparam int PROD_BITS   = 2 * VALUE_BITS;
  localparam int SUM_BITS    = ACC_BITS + 2;
  localparam int BUSY_BITS   = $clog2(2 * MAX_OUTPUTS + 1);

  typedef enum logic [1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_LOAD_BIAS   = 2'd1,
    OP_FEED        = 2'd2
  } dlf_op_t;

  typedef enum logic {
    CFG_INPUT_COUNT  = 1'b0,
    CFG_OUTPUT_COUNT = 1'b1
  } dlf_cfg_t;

  // item travelling down the row of cells
  typedef struct packed {
    logic                         wr_weight;
    logic                         wr_bias;
    logic                         add;
    logic                         last;
    logic [ROW_BITS-1:0]          row;
    logic [COL_BITS-1:0]          col;
    logic signed [VALUE_BITS-1:0] value;
  } dlf_tok_t;

  // result travelling back toward cell 0
  typedef struct packed {
    logic                         valid;
    logic                         last;
    logic [ROW_BITS-1:0]          row;
    logic signed [VALUE_BITS-1:0] bias;
    logic signed [ACC_BITS-1:0]   acc;
  } dlf_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dlf_cell.sv -----
`default_nettype none

module dlf_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [dlf_pkg::ROW_BITS-1:0]  row_id,
  input  wire logic [dlf_pkg::COUNT_BITS-1:0] n_out,
  input  wire dlf_pkg::dlf_tok_t             tok_in,
  output dlf_pkg::dlf_tok_t                  tok_out,
  input  wire dlf_pkg::dlf_res_t             lane_in,
  output dlf_pkg::dlf_res_t                  lane_out
);
  import dlf_pkg::*;

  logic signed [VALUE_BITS-1:0] wmem [MAX_INPUTS];
  logic signed [VALUE_BITS-1:0] rd;
  logic signed [VALUE_BITS-1:0] bias;
  logic signed [VALUE_BITS-1:0] s1_x;
  logic                         s1_add;
  logic                         s1_last;
  logic signed [PROD_BITS-1:0]  prod;
  logic                         s2_add;
  logic                         s2_last;
  logic signed [ACC_BITS-1:0]   acc;
  logic signed [ACC_BITS-1:0]   acc_next;
  logic                         mine;
  logic                         in_use;
  logic                         is_final;

  assign mine     = (tok_in.row == row_id);
  assign in_use   = ({1'b0, row_id} < n_out);
  assign is_final = (({1'b0, row_id} + COUNT_BITS'(1)) == n_out);
  // rows beyond the output count add nothing to their accumulator
  assign acc_next = acc + ((s2_add && in_use) ? {{(ACC_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod}
                                              : ACC_BITS'(0));

  // weight row of this output, registered read
  always_ff @(posedge clk) begin
    if (tok_in.wr_weight && mine) begin
      wmem[tok_in.col] <= tok_in.value;
    end
    rd <= wmem[tok_in.col];
  end

  always_ff @(posedge clk) begin
    if (tok_in.wr_bias && mine) begin
      bias <= tok_in.value;
    end
    s1_x <= tok_in.value;
    prod <= rd * s1_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out  <= '0;
      s1_add   <= 1'b0;
      s1_last  <= 1'b0;
      s2_add   <= 1'b0;
      s2_last  <= 1'b0;
      acc      <= '0;
      lane_out <= '0;
    end else begin
      tok_out <= tok_in;
      s1_add  <= tok_in.add;
      s1_last <= tok_in.last;
      s2_add  <= s1_add;
      s2_last <= s1_last;
      if (s2_last) begin
        acc <= '0;
      end else begin
        acc <= acc_next;
      end
      // own result takes the lane slot; results from later rows never land here now
      if (s2_last && in_use) begin
        lane_out.valid <= 1'b1;
        lane_out.last  <= is_final;
        lane_out.row   <= row_id;
        lane_out.bias  <= bias;
        lane_out.acc   <= acc_next;
      end else begin
        lane_out <= lane_in;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dlf_post.sv -----
`default_nettype none

module dlf_post (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire dlf_pkg::dlf_res_t                    res,
  output logic                                      out_valid,
  output logic signed [dlf_pkg::VALUE_BITS-1:0]     out_value,
  output logic [dlf_pkg::ROW_BITS-1:0]              out_row,
  output logic                                      out_saturated,
  output logic                                      out_last
);
  import dlf_pkg::*;

  localparam int Q_BITS = SUM_BITS - FRAC_BITS;
  localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [Q_BITS-1:0] VMAX = Q_BITS'((1 << (VALUE_BITS - 1)) - 1);
  localparam logic signed [Q_BITS-1:0] VMIN = -VMAX - Q_BITS'(1);

  logic signed [SUM_BITS-1:0] sum_next;
  logic signed [SUM_BITS-1:0] sum;
  logic                       a_valid;
  logic                       a_last;
  logic [ROW_BITS-1:0]        a_row;
  logic signed [Q_BITS-1:0]   q;

  assign sum_next = {{(SUM_BITS-ACC_BITS){res.acc[ACC_BITS-1]}}, res.acc}
                  + {{(SUM_BITS-VALUE_BITS-FRAC_BITS){res.bias[VALUE_BITS-1]}},
                     res.bias, {FRAC_BITS{1'b0}}}
                  + ROUND_HALF;
  // floor division by the fraction scale
  assign q = sum[SUM_BITS-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    sum   <= sum_next;
    a_row <= res.row;
    out_row <= a_row;
    if (q > VMAX) begin
      out_value     <= VMAX[VALUE_BITS-1:0];
      out_saturated <= 1'b1;
    end else if (q < VMIN) begin
      out_value     <= VMIN[VALUE_BITS-1:0];
      out_saturated <= 1'b1;
    end else begin
      out_value     <= q[VALUE_BITS-1:0];
      out_saturated <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      a_last    <= 1'b0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      a_valid   <= res.valid;
      a_last    <= res.last;
      out_valid <= a_valid;
      out_last  <= a_last && a_valid;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dense_layer_forward.sv -----
`default_nettype none

// Fully connected layer y = W x + b in signed Q8.8, one cell per output row.
// Items (weight load, bias load, input element) are taken one per cycle while
// busy is low and walk down the row of cells one cell per clock; each cell
// holds its own weight row, bias and 48-bit accumulator, so a feed does all
// multiply-adds of that element as it passes. busy is high only after a feed
// marked last; its count-down, loaded from the output count (capped at 64),
// keeps successive result bursts apart on the lane.
// Results travel back toward cell 0 and leave through the rounding and
// saturation stage with out_valid high for one cycle each, in row order.
// The receiver cannot hold results off. Counts are to be written through the
// cfg port only while the block is idle; the block does not enforce this.
module dense_layer_forward (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [1:0]                           opcode,
  input  wire logic [dlf_pkg::ROW_BITS-1:0]         row_index,
  input  wire logic [dlf_pkg::COL_BITS-1:0]         col_index,
  input  wire logic signed [dlf_pkg::VALUE_BITS-1:0] value,
  input  wire logic                                 last_element,
  input  wire logic                                 cfg_write,
  input  wire logic                                 cfg_index,
  input  wire logic [dlf_pkg::COUNT_BITS-1:0]       cfg_data,
  output logic                                      out_valid,
  output logic signed [dlf_pkg::VALUE_BITS-1:0]     out_value,
  output logic [dlf_pkg::ROW_BITS-1:0]              out_row,
  output logic                                      out_saturated,
  output logic                                      out_last
);
  import dlf_pkg::*;

  logic [COUNT_BITS-1:0] input_count;
  logic [COUNT_BITS-1:0] output_count;
  logic [COUNT_BITS-1:0] n_in;
  logic [COUNT_BITS-1:0] n_out;
  logic [BUSY_BITS-1:0]  busy_cnt;
  logic [BUSY_BITS-1:0]  busy_cnt_next;
  logic                  accept;
  dlf_tok_t              tok_head;
  dlf_tok_t              tok_head_next;
  dlf_tok_t              tok  [MAX_OUTPUTS+1];
  dlf_res_t              lane [MAX_OUTPUTS+1];

  assign n_in  = (input_count > COUNT_BITS'(MAX_INPUTS)) ? COUNT_BITS'(MAX_INPUTS)
                                                         : input_count;
  assign n_out = (output_count > COUNT_BITS'(MAX_OUTPUTS)) ? COUNT_BITS'(MAX_OUTPUTS)
                                                           : output_count;
  assign busy   = (busy_cnt != '0);
  assign accept = start && !busy;

  always_comb begin
    tok_head_next       = '0;
    tok_head_next.row   = row_index;
    tok_head_next.col   = col_index;
    tok_head_next.value = value;
    busy_cnt_next       = busy ? busy_cnt - BUSY_BITS'(1) : busy_cnt;
    if (accept) begin
      unique case (opcode)
        OP_LOAD_WEIGHT: tok_head_next.wr_weight = 1'b1;
        OP_LOAD_BIAS:   tok_head_next.wr_bias   = 1'b1;
        OP_FEED: begin
          tok_head_next.add  = ({1'b0, col_index} < n_in);
          tok_head_next.last = last_element;
          // keep successive result bursts apart on the lane
          if (last_element) begin
            busy_cnt_next = {n_out, 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_count  <= COUNT_BITS'(MAX_INPUTS);
      output_count <= COUNT_BITS'(MAX_OUTPUTS);
      busy_cnt     <= '0;
      tok_head     <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_INPUT_COUNT:  input_count  <= cfg_data;
          CFG_OUTPUT_COUNT: output_count <= cfg_data;
          default: ;
        endcase
      end
      busy_cnt <= busy_cnt_next;
      tok_head <= tok_head_next;
    end
  end

  assign tok[0]            = tok_head;
  assign lane[MAX_OUTPUTS] = '0;

  for (genvar i = 0; i < MAX_OUTPUTS; i++) begin : g_cell
    dlf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .row_id   (ROW_BITS'(i)),
      .n_out    (n_out),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1]),
      .lane_in  (lane[i+1]),
      .lane_out (lane[i])
    );
  end

  dlf_post u_post (
    .clk           (clk),
    .rst           (rst),
    .res           (lane[0]),
    .out_valid     (out_valid),
    .out_value     (out_value),
    .out_row       (out_row),
    .out_saturated (out_saturated),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/dlf_chk.sv -----
`default_nettype none

`include "dense_layer_forward_macros.svh"

module dlf_chk (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          out_valid,
  input wire logic [dlf_pkg::ROW_BITS-1:0]  out_row,
  input wire logic                          out_last
);

  // reset leaves nothing pending on either side
  `DLF_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, rst, !busy && !out_valid)

  // no result directly follows another on the output
  `DLF_ASSERT_NEXT(a_spaced, clk, rst, out_valid, !out_valid)

  // a row that is not the final one is followed by the next row
  `DLF_ASSERT_AFTER2(a_row_order, clk, rst, out_valid && !out_last,
    out_valid && (out_row == $past(out_row, 2) + 1'b1))

  // busy rises only on a transfer
  `DLF_ASSERT_NEXT(a_busy_on_transfer, clk, rst, !busy && !start, !busy)

endmodule

bind dense_layer_forward dlf_chk u_dlf_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_row   (out_row),
  .out_last  (out_last)
);

`default_nettype wire
